### hw/rtl/dsfmt_pkg.sv
package dsfmt_pkg;

    localparam int WORD_COUNT_DEF  = 191;
    localparam int PICK_OFFSET_DEF = 117;
    localparam int LEFT_SHIFT_DEF  = 19;
    localparam int RIGHT_SHIFT_DEF = 12;

    localparam logic [31:0] SEED_MULT    = 32'd1812433253;
    localparam logic [63:0] FRAC_BITS    = 64'h000F_FFFF_FFFF_FFFF;
    localparam logic [63:0] ONE_EXPONENT = 64'h3FF0_0000_0000_0000;

    localparam logic [2:0] REG_MASK_LO = 3'd0;
    localparam logic [2:0] REG_MASK_HI = 3'd1;
    localparam logic [2:0] REG_FIX_LO  = 3'd2;
    localparam logic [2:0] REG_FIX_HI  = 3'd3;
    localparam logic [2:0] REG_CERT_LO = 3'd4;
    localparam logic [2:0] REG_CERT_HI = 3'd5;

    localparam logic REQ_SEED = 1'b0;
    localparam logic REQ_NEXT = 1'b1;

    typedef struct packed {
        logic        is_next;
        logic [31:0] seed;
    } t_cmd;

    typedef struct packed {
        logic [63:0] bits;
        logic        not_seeded;
    } t_result;

endpackage

### hw/rtl/dsfmt_front.sv
module dsfmt_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [39:0]          s_axis_tdata,
    input  logic                 i_q_ready,
    output logic                 o_q_valid,
    output dsfmt_pkg::t_cmd      o_q_cmd
);
    // two-entry queue of decoded requests
    dsfmt_pkg::t_cmd r_mem [2];
    logic            r_wp, r_rp;
    logic [1:0]      r_cnt;
    logic            w_push, w_pop;

    assign s_axis_tready = (r_cnt != 2'd2);
    assign w_push = s_axis_tvalid && s_axis_tready;
    assign w_pop  = o_q_valid && i_q_ready;
    assign o_q_valid = (r_cnt != 2'd0);
    assign o_q_cmd = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wp].is_next <= (s_axis_tdata[0] == dsfmt_pkg::REQ_NEXT);
            r_mem[r_wp].seed    <= s_axis_tdata[32:1];
        end
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) r_wp <= ~r_wp;
            if (w_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, w_pop};
        end
    end
endmodule

### hw/rtl/dsfmt_back.sv
module dsfmt_back #(
    parameter int WORD_COUNT  = dsfmt_pkg::WORD_COUNT_DEF,
    parameter int PICK_OFFSET = dsfmt_pkg::PICK_OFFSET_DEF,
    parameter int LEFT_SHIFT  = dsfmt_pkg::LEFT_SHIFT_DEF,
    parameter int RIGHT_SHIFT = dsfmt_pkg::RIGHT_SHIFT_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_q_valid,
    output logic                 o_q_ready,
    input  dsfmt_pkg::t_cmd      i_q_cmd,
    input  logic [63:0]          i_mask_lo,
    input  logic [63:0]          i_mask_hi,
    input  logic [63:0]          i_fix_lo,
    input  logic [63:0]          i_fix_hi,
    input  logic [63:0]          i_cert_lo,
    input  logic [63:0]          i_cert_hi,
    output logic                 o_res_valid,
    input  logic                 i_res_ready,
    output dsfmt_pkg::t_result   o_res
);
    localparam int AW = $clog2(WORD_COUNT);
    localparam int PW = $clog2(2 * WORD_COUNT + 1);
    localparam int SW = $clog2(4 * WORD_COUNT + 4);
    localparam logic [AW-1:0] LAST_W = AW'(WORD_COUNT - 1);
    localparam logic [PW-1:0] POS_END = PW'(2 * WORD_COUNT);
    localparam logic [SW-1:0] PIECE_END = SW'(4 * WORD_COUNT + 4);
    localparam logic [AW-1:0] PICK0 = AW'(PICK_OFFSET % WORD_COUNT);

    typedef enum logic [3:0] {
        ST_IDLE, ST_SEED, ST_CERT, ST_RD, ST_RD_WAIT, ST_OUT,
        ST_GEN_A, ST_GEN_B, ST_GEN_C, ST_GEN_D
    } t_state;

    // state word memory, one 128-bit word per entry; lung held in registers
    logic [127:0]  r_mem [WORD_COUNT];
    logic [127:0]  r_rdata;
    logic [AW-1:0] r_raddr;
    logic          r_we;
    logic [AW-1:0] r_waddr;
    logic [127:0]  r_wdata;

    t_state        r_state;
    logic          r_seeded;
    logic [PW-1:0] r_pos;
    logic [SW-1:0] r_piece;
    logic [31:0]   r_x;
    logic [95:0]   r_acc;
    logic [63:0]   r_l0, r_l1;
    logic [AW-1:0] r_i, r_j;
    logic [127:0]  r_a;
    logic          r_out_valid;
    dsfmt_pkg::t_result r_out;

    logic [31:0]  w_xs, w_mul, w_xn;
    logic [63:0]  w_t, w_n0, w_n1, w_b0, w_b1;
    logic         w_par;

    assign o_q_ready   = (r_state == ST_IDLE) && !r_out_valid;
    assign o_res_valid = r_out_valid;
    assign o_res       = r_out;

    assign w_xs  = r_x ^ (r_x >> 30);
    assign w_mul = w_xs * dsfmt_pkg::SEED_MULT;
    assign w_xn  = w_mul + 32'(r_piece);

    assign w_t   = ((r_l0 ^ i_fix_lo) & i_cert_lo) ^ ((r_l1 ^ i_fix_hi) & i_cert_hi);
    assign w_par = ^w_t;

    assign w_b0 = r_rdata[63:0];
    assign w_b1 = r_rdata[127:64];
    assign w_n0 = (r_a[63:0] << LEFT_SHIFT) ^ (r_l1 >> 32) ^ (r_l1 << 32) ^ w_b0;
    assign w_n1 = (r_a[127:64] << LEFT_SHIFT) ^ (r_l0 >> 32) ^ (r_l0 << 32) ^ w_b1;

    always_ff @(posedge i_clk) begin
        if (r_we) r_mem[r_waddr] <= r_wdata;
        r_rdata <= r_mem[r_raddr];
    end

    always_ff @(posedge i_clk) begin
        r_we <= 1'b0;
        if (i_res_ready) r_out_valid <= 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_q_valid && o_q_ready) begin
                    if (!i_q_cmd.is_next) begin
                        r_x     <= i_q_cmd.seed;
                        r_acc   <= {64'd0, i_q_cmd.seed};
                        r_piece <= SW'(1);
                        r_state <= ST_SEED;
                    end else if (!r_seeded) begin
                        r_out       <= '{bits: 64'd0, not_seeded: 1'b1};
                        r_out_valid <= 1'b1;
                    end else if (r_pos == POS_END) begin
                        r_i <= '0;
                        r_j <= PICK0;
                        r_raddr <= '0;
                        r_state <= ST_GEN_A;
                    end else begin
                        r_raddr <= r_pos[PW-1:1];
                        r_state <= ST_RD;
                    end
                end
            end
            // one 32-bit piece per cycle, a word written every fourth piece
            ST_SEED: begin
                r_x <= w_xn;
                if (r_piece[1:0] == 2'd3) begin
                    if (r_piece == PIECE_END - SW'(1)) begin
                        r_l0 <= r_acc[63:0];
                        r_l1 <= {w_xn, r_acc[95:64]};
                        r_state <= ST_CERT;
                    end else begin
                        r_we    <= 1'b1;
                        r_waddr <= r_piece[SW-1:2];
                        r_wdata <= {(({w_xn, r_acc[95:64]} & dsfmt_pkg::FRAC_BITS)
                                     | dsfmt_pkg::ONE_EXPONENT),
                                    ((r_acc[63:0] & dsfmt_pkg::FRAC_BITS)
                                     | dsfmt_pkg::ONE_EXPONENT)};
                    end
                end else if (r_piece[1:0] == 2'd0) begin
                    r_acc[31:0] <= w_xn;
                end else if (r_piece[1:0] == 2'd1) begin
                    r_acc[63:32] <= w_xn;
                end else begin
                    r_acc[95:64] <= w_xn;
                end
                r_piece <= r_piece + SW'(1);
            end
            ST_CERT: begin
                if (!w_par) begin
                    if (i_cert_hi != 64'd0) r_l1 <= r_l1 ^ (i_cert_hi & (-i_cert_hi));
                    else if (i_cert_lo != 64'd0) r_l0 <= r_l0 ^ (i_cert_lo & (-i_cert_lo));
                end
                r_seeded    <= 1'b1;
                r_pos       <= POS_END;
                r_out       <= '{bits: 64'd0, not_seeded: 1'b0};
                r_out_valid <= 1'b1;
                r_state     <= ST_IDLE;
            end
            ST_RD: r_state <= ST_RD_WAIT;
            ST_RD_WAIT: r_state <= ST_OUT;
            ST_OUT: begin
                r_out.bits       <= r_pos[0] ? w_b1 : w_b0;
                r_out.not_seeded <= 1'b0;
                r_out_valid      <= 1'b1;
                r_pos            <= r_pos + PW'(1);
                r_state          <= ST_IDLE;
            end
            // recursion: read a[i], then b[j], then write
            ST_GEN_A: begin
                r_raddr <= r_j;
                r_state <= ST_GEN_B;
            end
            ST_GEN_B: begin
                r_a     <= r_rdata;
                r_state <= ST_GEN_C;
            end
            ST_GEN_C: r_state <= ST_GEN_D;
            ST_GEN_D: begin
                r_l0    <= w_n0;
                r_l1    <= w_n1;
                r_we    <= 1'b1;
                r_waddr <= r_i;
                r_wdata <= {((w_n1 >> RIGHT_SHIFT) ^ (w_n1 & i_mask_hi) ^ r_a[127:64]),
                            ((w_n0 >> RIGHT_SHIFT) ^ (w_n0 & i_mask_lo) ^ r_a[63:0])};
                if (r_i == LAST_W) begin
                    r_pos   <= '0;
                    r_raddr <= '0;
                    r_state <= ST_RD;
                end else begin
                    r_i     <= r_i + AW'(1);
                    r_raddr <= r_i + AW'(1);
                    r_j     <= (r_j == LAST_W) ? '0 : r_j + AW'(1);
                    r_state <= ST_GEN_A;
                end
            end
            default: r_state <= ST_IDLE;
        endcase
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_seeded    <= 1'b0;
            r_pos       <= '0;
            r_out_valid <= 1'b0;
            r_we        <= 1'b0;
        end
    end
endmodule

### hw/rtl/dsfmt_double_generator.sv
// Double-precision generator with 128-bit state words. A request with
// req_type 0 seeds the generator (one 32-bit seed piece per cycle through
// the seed multiplier) and returns zero; a request with req_type 1 returns
// the next [1,2) double pattern via ST_RD, ST_RD_WAIT and ST_OUT, which wait
// out the registered read of the state memory. Every 2*WORD_COUNT results a
// refill runs first, each word taking ST_GEN_A to ST_GEN_D (two reads on one
// memory port and a write). Requests are queued two deep.
module dsfmt_double_generator #(
    parameter int WORD_COUNT  = dsfmt_pkg::WORD_COUNT_DEF,
    parameter int PICK_OFFSET = dsfmt_pkg::PICK_OFFSET_DEF,
    parameter int LEFT_SHIFT  = dsfmt_pkg::LEFT_SHIFT_DEF,
    parameter int RIGHT_SHIFT = dsfmt_pkg::RIGHT_SHIFT_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // req_type, seed_value
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,   // random_bits
    output logic        m_axis_tuser,   // not_seeded
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [63:0] i_cfg_data
);
    logic cfg_wr;
    logic [63:0] r_mask_lo, r_mask_hi, r_fix_lo, r_fix_hi, r_cert_lo, r_cert_hi;
    logic q_valid, q_ready;
    dsfmt_pkg::t_cmd q_cmd;
    dsfmt_pkg::t_result res;

    assign o_cfg_ready = 1'b1;
    assign cfg_wr = i_cfg_valid && o_cfg_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask_lo <= '0; r_mask_hi <= '0; r_fix_lo <= '0;
            r_fix_hi  <= '0; r_cert_lo <= '0; r_cert_hi <= 64'd1;
        end else if (cfg_wr) begin
            unique case (i_cfg_index)
                dsfmt_pkg::REG_MASK_LO: r_mask_lo <= i_cfg_data;
                dsfmt_pkg::REG_MASK_HI: r_mask_hi <= i_cfg_data;
                dsfmt_pkg::REG_FIX_LO:  r_fix_lo  <= i_cfg_data;
                dsfmt_pkg::REG_FIX_HI:  r_fix_hi  <= i_cfg_data;
                dsfmt_pkg::REG_CERT_LO: r_cert_lo <= i_cfg_data;
                dsfmt_pkg::REG_CERT_HI: r_cert_hi <= i_cfg_data;
                default: ;
            endcase
        end
    end

    dsfmt_front u_front (
        .i_clk, .i_rst_n, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
        .i_q_ready(q_ready), .o_q_valid(q_valid), .o_q_cmd(q_cmd)
    );

    dsfmt_back #(
        .WORD_COUNT(WORD_COUNT), .PICK_OFFSET(PICK_OFFSET),
        .LEFT_SHIFT(LEFT_SHIFT), .RIGHT_SHIFT(RIGHT_SHIFT)
    ) u_back (
        .i_clk, .i_rst_n, .i_q_valid(q_valid), .o_q_ready(q_ready), .i_q_cmd(q_cmd),
        .i_mask_lo(r_mask_lo), .i_mask_hi(r_mask_hi), .i_fix_lo(r_fix_lo),
        .i_fix_hi(r_fix_hi), .i_cert_lo(r_cert_lo), .i_cert_hi(r_cert_hi),
        .o_res_valid(m_axis_tvalid), .i_res_ready(m_axis_tready), .o_res(res)
    );

    assign m_axis_tdata = res.bits;
    assign m_axis_tuser = res.not_seeded;

`ifndef SYNTHESIS
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == 64'd0)
        else $error("error result carries data");
    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tuser))
        else $error("result changed while waiting");
`endif
endmodule

### bench/tb_dsfmt_double_generator.sv
module tb_dsfmt_double_generator;

    localparam int NWORDS     = dsfmt_pkg::WORD_COUNT_DEF;
    localparam int STALL_LIMIT = 20000;
    localparam logic [2:0] REG_INDEX_OOR = 3'd7;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata;   // req_type, seed_value
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [63:0] m_axis_tdata;   // random_bits
    logic        m_axis_tuser;   // not_seeded
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index;
    logic [63:0] i_cfg_data;

    int  n_errors;
    int  idle_cycles;
    bit  quiet_mode;
    bit  sink_on;

    dsfmt_double_generator i_dut (.*);

    always begin
        i_clk = 1'b0; #5;
        i_clk = 1'b1; #5;
    end

    task automatic report_mismatch(input string msg);
        $display("MISMATCH: %s", msg);
        n_errors++;
    endtask

    class dsfmt_scoreboard;
        logic [63:0] regs [6];
        logic [63:0] words [NWORDS+1][2];
        int          rd_pos;
        bit          seeded;
        logic [63:0] exp_bits [$];
        bit          exp_flag [$];

        function new();
            foreach (regs[i]) regs[i] = '0;
            regs[dsfmt_pkg::REG_CERT_HI] = 64'd1;
            rd_pos = 0;
            seeded = 0;
        endfunction

        function void write_reg(logic [2:0] idx, logic [63:0] val);
            if (idx <= dsfmt_pkg::REG_CERT_HI) regs[idx] = val;
        endfunction

        function void fix_period();
            logic [63:0] t;
            logic [63:0] ch;
            logic [63:0] cl;
            ch = regs[dsfmt_pkg::REG_CERT_HI];
            cl = regs[dsfmt_pkg::REG_CERT_LO];
            t = ((words[NWORDS][0] ^ regs[dsfmt_pkg::REG_FIX_LO]) & cl)
              ^ ((words[NWORDS][1] ^ regs[dsfmt_pkg::REG_FIX_HI]) & ch);
            if (^t) return;
            if (ch != 0) words[NWORDS][1] ^= ch & (~ch + 64'd1);
            else if (cl != 0) words[NWORDS][0] ^= cl & (~cl + 64'd1);
        endfunction

        function void load_seed(logic [31:0] seed);
            logic [31:0] x;
            int w;
            int h;
            x = seed;
            for (int i = 0; i < (NWORDS + 1) * 4; i++) begin
                if (i > 0) x = dsfmt_pkg::SEED_MULT * (x ^ (x >> 30)) + 32'(i);
                w = i >> 2;
                h = (i >> 1) & 1;
                if (i & 1) words[w][h][63:32] = x;
                else       words[w][h][31:0] = x;
            end
            for (int i = 0; i < NWORDS; i++)
                for (int k = 0; k < 2; k++)
                    words[i][k] = (words[i][k] & dsfmt_pkg::FRAC_BITS)
                                | dsfmt_pkg::ONE_EXPONENT;
            fix_period();
            rd_pos = 2 * NWORDS;
            seeded = 1;
        endfunction

        function void refill();
            logic [63:0] l0, l1, a0, a1, n0, n1;
            int j;
            l0 = words[NWORDS][0];
            l1 = words[NWORDS][1];
            for (int i = 0; i < NWORDS; i++) begin
                j = (i + dsfmt_pkg::PICK_OFFSET_DEF) % NWORDS;
                a0 = words[i][0];
                a1 = words[i][1];
                n0 = (a0 << dsfmt_pkg::LEFT_SHIFT_DEF) ^ (l1 >> 32) ^ (l1 << 32)
                   ^ words[j][0];
                n1 = (a1 << dsfmt_pkg::LEFT_SHIFT_DEF) ^ (l0 >> 32) ^ (l0 << 32)
                   ^ words[j][1];
                l0 = n0;
                l1 = n1;
                words[i][0] = (l0 >> dsfmt_pkg::RIGHT_SHIFT_DEF)
                            ^ (l0 & regs[dsfmt_pkg::REG_MASK_LO]) ^ a0;
                words[i][1] = (l1 >> dsfmt_pkg::RIGHT_SHIFT_DEF)
                            ^ (l1 & regs[dsfmt_pkg::REG_MASK_HI]) ^ a1;
            end
            words[NWORDS][0] = l0;
            words[NWORDS][1] = l1;
        endfunction

        function void note_request(logic [39:0] data);
            if (data[0] == dsfmt_pkg::REQ_SEED) begin
                load_seed(data[32:1]);
                exp_bits.push_back('0);
                exp_flag.push_back(1'b0);
            end else if (!seeded) begin
                exp_bits.push_back('0);
                exp_flag.push_back(1'b1);
            end else begin
                if (rd_pos >= 2 * NWORDS) begin
                    refill();
                    rd_pos = 0;
                end
                exp_bits.push_back(words[rd_pos >> 1][rd_pos & 1]);
                exp_flag.push_back(1'b0);
                rd_pos++;
            end
        endfunction

        task check_result(logic [63:0] bits, logic flag);
            if (exp_bits.size() == 0) begin
                report_mismatch($sformatf("unexpected result %h", bits));
                return;
            end
            if (bits !== exp_bits[0])
                report_mismatch($sformatf("random_bits %h, want %h", bits, exp_bits[0]));
            if (flag !== exp_flag[0])
                report_mismatch($sformatf("not_seeded %b, want %b", flag, exp_flag[0]));
            void'(exp_bits.pop_front());
            void'(exp_flag.pop_front());
        endtask

        function int pending();
            return exp_bits.size();
        endfunction
    endclass

    dsfmt_scoreboard sb;

    // result side and watchdog
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata, m_axis_tuser);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                || (i_cfg_valid && o_cfg_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    always @(negedge i_clk) begin
        if (!sink_on) m_axis_tready <= 1'b0;
        else if (quiet_mode) m_axis_tready <= 1'b1;
        else m_axis_tready <= ($urandom_range(99) >= 27);
    end

    // valid stays high after a request; an idle gap or the drain drops it
    task automatic send_request(input logic req, input logic [31:0] seed);
        i_cfg_valid <= 1'b0;
        if (!quiet_mode)
            while ($urandom_range(99) < 27) begin
                s_axis_tvalid <= 1'b0;
                @(negedge i_clk);
            end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {7'd0, seed, req};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        sb.note_request(s_axis_tdata);
        @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        sb.write_reg(idx, val);
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        i_cfg_valid <= 1'b0;
        while (sb.pending() != 0) @(negedge i_clk);
        repeat (20) @(negedge i_clk);
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    task automatic run_nexts(input int count, input bit allow_reseed);
        for (int i = 0; i < count; i++) begin
            if (allow_reseed && $urandom_range(99) < 3)
                send_request(dsfmt_pkg::REQ_SEED, $urandom());
            else
                send_request(dsfmt_pkg::REQ_NEXT, $urandom());
        end
    endtask

    initial begin
        sb = new();
        n_errors = 0;
        idle_cycles = 0;
        quiet_mode = 0;
        sink_on = 0;
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        m_axis_tready = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;
        sink_on = 1;

        // next before any seed, then seed extremes with default registers
        send_request(dsfmt_pkg::REQ_NEXT, 32'hFFFF_FFFF);
        send_request(dsfmt_pkg::REQ_NEXT, 32'h0);
        send_request(dsfmt_pkg::REQ_SEED, 32'h0);
        send_request(dsfmt_pkg::REQ_NEXT, 32'h0);
        send_request(dsfmt_pkg::REQ_SEED, 32'hFFFF_FFFF);
        run_nexts(4, 1'b1);
        send_request(dsfmt_pkg::REQ_SEED, 32'd4357);
        send_request(dsfmt_pkg::REQ_NEXT, 32'hFFFF_FFFF);
        wait_drained();

        // certify vector all zero: no flip at all
        write_reg(dsfmt_pkg::REG_CERT_HI, 64'd0);
        write_reg(dsfmt_pkg::REG_CERT_LO, 64'd0);
        write_reg(REG_INDEX_OOR, 64'hDEAD);
        send_request(dsfmt_pkg::REQ_SEED, 32'd1);
        send_request(dsfmt_pkg::REQ_NEXT, 32'd0);
        wait_drained();
        // low half certification only
        write_reg(dsfmt_pkg::REG_CERT_LO, 64'h8000_0000_0000_0000);
        write_reg(dsfmt_pkg::REG_FIX_LO, '1);
        write_reg(dsfmt_pkg::REG_FIX_HI, '1);
        send_request(dsfmt_pkg::REQ_SEED, 32'd2);
        send_request(dsfmt_pkg::REQ_SEED, 32'd3);
        send_request(dsfmt_pkg::REQ_NEXT, 32'd0);
        wait_drained();

        // random registers, one seed and enough nexts to cross a refill,
        // with a stretch where neither side idles
        write_reg(dsfmt_pkg::REG_MASK_LO, rand64());
        write_reg(dsfmt_pkg::REG_MASK_HI, rand64());
        write_reg(dsfmt_pkg::REG_FIX_LO, rand64());
        write_reg(dsfmt_pkg::REG_FIX_HI, rand64());
        write_reg(dsfmt_pkg::REG_CERT_LO, rand64());
        write_reg(dsfmt_pkg::REG_CERT_HI, rand64());
        send_request(dsfmt_pkg::REQ_SEED, $urandom());
        run_nexts(150, 1'b0);
        quiet_mode = 1;
        run_nexts(100, 1'b0);
        quiet_mode = 0;
        run_nexts(140, 1'b0);
        wait_drained();

        // typical parameter set with reseeds mixed in
        write_reg(dsfmt_pkg::REG_MASK_LO, 64'h000F_FAFD_FFFF_FFFF);
        write_reg(dsfmt_pkg::REG_MASK_HI, 64'h000F_F6EF_FFFF_FFFF);
        write_reg(dsfmt_pkg::REG_FIX_LO, 64'h9001_9F80_6A13_0B61);
        write_reg(dsfmt_pkg::REG_FIX_HI, 64'hB6F1_D1AC_C017_E8BD);
        write_reg(dsfmt_pkg::REG_CERT_LO, 64'h3D84_E1AC_0DC8_2880);
        write_reg(dsfmt_pkg::REG_CERT_HI, 64'h0000_0000_0000_0001);
        send_request(dsfmt_pkg::REQ_SEED, $urandom());
        run_nexts(40, 1'b1);
        wait_drained();

        while (sb.pending() != 0) @(negedge i_clk);
        repeat (50) @(negedge i_clk);
        if (n_errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
